>>> sv/vrt_pkg.sv
package vrt_pkg;

    localparam int unsigned TW = 32;
    localparam int unsigned CW = 16;
    localparam logic [TW-1:0] T_INF = '1;
    localparam logic [TW-1:0] MAXD_RESET = 32'h0040_0000;

    localparam logic [1:0] ST_PROBE = 2'd0;
    localparam logic [1:0] ST_HIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_IDLE = 2'd3;

    localparam logic [1:0] SG_NONE = 2'd0;
    localparam logic [1:0] SG_POS = 2'd1;
    localparam logic [1:0] SG_NEG = 2'd3;

    typedef struct packed {
        logic kind;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic solid;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic signed [15:0] prev_x;
        logic signed [15:0] prev_y;
        logic signed [15:0] prev_z;
        logic [1:0] status;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // latch start voxel, signs and first-boundary distances
        logic div_start;  // start reciprocal of axis div_axis
        logic [1:0] div_axis;
        logic step;       // take one traversal step
        logic hit;        // end ray on a hit
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
        logic active;
    } t_sts;

endpackage

>>> sv/vrt_div.sv
// Restoring divider: quotient = 2^31 / mag, one bit per cycle.
module vrt_div (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [16:0] i_mag,
    output logic o_done,
    output logic [31:0] o_quot
);
    import vrt_pkg::*;

    logic [17:0] r_rem;
    logic [31:0] r_quot;
    logic [5:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [16:0] r_mag;
    logic [17:0] w_sh;
    logic w_bit;

    // Dividend has a single one at bit 31; shift in that bit on the first step.
    assign w_sh = {r_rem[16:0], (r_cnt == 6'd0)};
    assign w_bit = (w_sh >= {1'b0, r_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_mag <= i_mag;
            end else if (r_busy) begin
                r_rem <= w_bit ? (w_sh - {1'b0, r_mag}) : w_sh;
                r_quot <= {r_quot[30:0], w_bit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> sv/vrt_datapath.sv
// Per-axis traversal state, reciprocal unit, crossing multiply and step logic.
module vrt_datapath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  vrt_pkg::t_in_item i_item,
    input  logic [31:0] i_max_dist,
    input  vrt_pkg::t_cmd i_cmd,
    output vrt_pkg::t_sts o_sts,
    output logic [15:0] o_pos [3],
    output logic [15:0] o_prev [3],
    output logic o_range
);
    import vrt_pkg::*;

    logic [15:0] r_pos [3];
    logic [15:0] r_prev [3];
    logic [1:0] r_sign [3];
    logic [15:0] r_dist [3];
    logic [16:0] r_mag [3];
    logic [TW-1:0] r_delta [3];
    logic [TW-1:0] r_cross [3];
    logic r_active;
    logic r_mul_v;
    logic [1:0] r_mul_ax;
    logic [47:0] r_prod;

    logic [31:0] w_start [3];
    logic [15:0] w_dir [3];
    logic w_div_done;
    logic [31:0] w_quot;
    logic [1:0] w_ax;
    logic [32:0] w_sum;
    logic [TW-1:0] w_adv;

    assign w_start[0] = i_item.start_x;
    assign w_start[1] = i_item.start_y;
    assign w_start[2] = i_item.start_z;
    assign w_dir[0] = i_item.dir_x;
    assign w_dir[1] = i_item.dir_y;
    assign w_dir[2] = i_item.dir_z;

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (r_mag[i_cmd.div_axis]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Axis of smallest crossing; a tie goes to the later axis (Z over Y over X).
    always_comb begin
        if (r_cross[0] < r_cross[1]) begin
            w_ax = (r_cross[0] < r_cross[2]) ? 2'd0 : 2'd2;
        end else begin
            w_ax = (r_cross[1] < r_cross[2]) ? 2'd1 : 2'd2;
        end
    end

    assign w_sum = {1'b0, r_cross[w_ax]} + {1'b0, r_delta[w_ax]};
    assign w_adv = w_sum[32] ? T_INF : w_sum[31:0];
    assign o_range = (r_cross[w_ax] == T_INF) || (r_cross[w_ax] > i_max_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_mul_v <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_prev[i] <= '0;
                r_sign[i] <= SG_NONE;
                r_delta[i] <= T_INF;
                r_cross[i] <= T_INF;
            end
        end else begin
            r_mul_v <= 1'b0;
            // Load start voxel, signs and distance to first boundary.
            if (i_cmd.load) begin
                r_active <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_pos[i] <= w_start[i][31:16];
                    r_prev[i] <= w_start[i][31:16];
                    r_delta[i] <= T_INF;
                    r_cross[i] <= T_INF;
                    if (w_dir[i] == 16'd0) begin
                        r_sign[i] <= SG_NONE;
                        r_mag[i] <= '0;
                        r_dist[i] <= '0;
                    end else if (w_dir[i][15]) begin
                        r_sign[i] <= SG_NEG;
                        r_mag[i] <= 17'h10000 - {1'b0, w_dir[i]};
                        r_dist[i] <= w_start[i][15:0];
                    end else begin
                        r_sign[i] <= SG_POS;
                        r_mag[i] <= {1'b0, w_dir[i]};
                        r_dist[i] <= 16'd0 - w_start[i][15:0];
                    end
                end
            end
            // Quotient arrives: store delta and multiply for first crossing.
            if (w_div_done) begin
                r_delta[i_cmd.div_axis] <= w_quot;
                r_prod <= 48'(r_dist[i_cmd.div_axis]) * 48'(w_quot);
                r_mul_v <= 1'b1;
                r_mul_ax <= i_cmd.div_axis;
            end
            if (r_mul_v) begin
                r_cross[r_mul_ax] <= r_prod[47:16];
            end
            if (i_cmd.hit) begin
                r_active <= 1'b0;
            end
            // One traversal step.
            if (i_cmd.step) begin
                for (int i = 0; i < 3; i++) begin
                    r_prev[i] <= r_pos[i];
                end
                if (r_sign[w_ax] == SG_POS) begin
                    r_pos[w_ax] <= r_pos[w_ax] + 16'd1;
                end else if (r_sign[w_ax] == SG_NEG) begin
                    r_pos[w_ax] <= r_pos[w_ax] - 16'd1;
                end
                if (o_range) begin
                    r_active <= 1'b0;
                end else begin
                    r_cross[w_ax] <= w_adv;
                end
            end
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.active = r_active;
    assign o_pos = r_pos;
    assign o_prev = r_prev;
endmodule

>>> sv/vrt_ctrl.sv
// Sequencer: accepts items, runs reciprocals per axis, steps, drives the output.
module vrt_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  vrt_pkg::t_in_item i_item,
    output vrt_pkg::t_cmd o_cmd,
    input  vrt_pkg::t_sts i_sts,
    input  logic i_range,
    input  logic [15:0] i_pos [3],
    input  logic [15:0] i_prev [3],
    output logic o_valid,
    input  logic i_stall,
    output vrt_pkg::t_out_item o_item
);
    import vrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_CROSS, S_STEP, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0] r_axis;
    logic [1:0] r_status;
    logic r_valid;
    logic r_dir_nz [3];
    logic w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.div_axis = r_axis;
        o_cmd.load = w_acc && !i_item.kind;
        o_cmd.hit = w_acc && i_item.kind && i_sts.active && i_item.solid;
        o_cmd.div_start = (r_state == S_DIV) && r_dir_nz[r_axis];
        o_cmd.step = (r_state == S_STEP)
                  || (w_acc && i_item.kind && i_sts.active && !i_item.solid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_axis <= '0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (!i_item.kind) begin
                            r_dir_nz[0] <= (i_item.dir_x != 16'd0);
                            r_dir_nz[1] <= (i_item.dir_y != 16'd0);
                            r_dir_nz[2] <= (i_item.dir_z != 16'd0);
                            r_axis <= 2'd0;
                            r_state <= S_DIV;
                        end else begin
                            if (!i_sts.active) begin
                                r_status <= ST_IDLE;
                            end else if (i_item.solid) begin
                                r_status <= ST_HIT;
                            end else begin
                                r_status <= i_range ? ST_RANGE : ST_PROBE;
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= r_dir_nz[r_axis] ? S_MUL : S_CROSS;
                end
                S_MUL: begin
                    if (i_sts.div_done) begin
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    // Crossing written this cycle when multiply was used.
                    if (r_axis == 2'd2) begin
                        r_state <= S_STEP;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                S_STEP: begin
                    r_status <= i_range ? ST_RANGE : ST_PROBE;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && !r_valid) begin
                o_item.cell_x <= i_pos[0];
                o_item.cell_y <= i_pos[1];
                o_item.cell_z <= i_pos[2];
                o_item.prev_x <= i_prev[0];
                o_item.prev_y <= i_prev[1];
                o_item.prev_z <= i_prev[2];
                o_item.status <= r_status;
            end
        end
    end

    assign o_valid = r_valid;
endmodule

>>> sv/voxel_ray_traversal.sv
// 3D grid voxel traversal over unit voxels.
// Input channel (i_valid/o_stall, i_item): kind 0 starts a ray from a Q16.16
// start and a Q1.15 direction; kind 1 answers whether the last probed voxel
// is solid. Each accepted item yields exactly one result item on the output
// channel (o_valid/i_stall, o_item) with the current and previous voxel and
// a status: probe, hit, beyond max distance, or no active ray.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_data) writes the
// Q16.16 max distance; write it only while the block is idle.
// An answer item needs no divide or multiply; a new ray first runs a shared
// bit-serial divider that forms 1/|d| for each nonzero axis in turn (a zero
// axis is not divided), each quotient followed by the crossing multiply,
// before its first step.
// One item is in flight at a time; o_stall stays high until its result sits
// in the output register. If the receiver stalls, the result holds; one more
// item is taken and worked, and then o_stall stays high until the held result
// leaves.
// Reset leaves no active ray and no pending result, and max distance 64.0.
module voxel_ray_traversal (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  vrt_pkg::t_in_item i_item,
    output logic o_valid,
    input  logic i_stall,
    output vrt_pkg::t_out_item o_item,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import vrt_pkg::*;

    logic [31:0] r_max_dist;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_range;
    logic [15:0] w_pos [3];
    logic [15:0] w_prev [3];

    assign o_cfg_ready = 1'b1;

    // Max distance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAXD_RESET;
        end else if (i_cfg_valid) begin
            r_max_dist <= i_cfg_data;
        end
    end

    vrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts),
        .i_range (w_range),
        .i_pos   (w_pos),
        .i_prev  (w_prev),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    vrt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_max_dist (r_max_dist),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_pos      (w_pos),
        .o_prev     (w_prev),
        .o_range    (w_range)
    );
endmodule

>>> test/tb_voxel_ray_traversal.sv
`timescale 1ns / 100ps

module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_item i_item;
    logic o_valid;
    logic i_stall;
    t_out_item o_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [31:0] i_cfg_data;

    voxel_ray_traversal dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item(i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item(o_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 2000;

    // Predicted state of the traversal.
    logic [TW-1:0] pm_max_dist;
    logic [CW-1:0] pm_pos [3];
    logic [CW-1:0] pm_prev [3];
    logic [1:0] pm_sign [3];
    logic [TW-1:0] pm_delta [3];
    logic [TW-1:0] pm_cross [3];
    logic pm_active;

    t_out_item expected_voxels[$];
    int error_count;
    int idle_cycles;
    bit hold_receiver;
    int hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [1:0] advance_voxel();
        int ax;
        for (int i = 0; i < 3; i++) pm_prev[i] = pm_pos[i];
        if (pm_cross[0] < pm_cross[1]) ax = (pm_cross[0] < pm_cross[2]) ? 0 : 2;
        else ax = (pm_cross[1] < pm_cross[2]) ? 1 : 2;
        if (pm_sign[ax] == SG_POS) pm_pos[ax] = pm_pos[ax] + 16'd1;
        else if (pm_sign[ax] == SG_NEG) pm_pos[ax] = pm_pos[ax] - 16'd1;
        if (pm_cross[ax] == T_INF || pm_cross[ax] > pm_max_dist) begin
            pm_active = 1'b0;
            return ST_RANGE;
        end
        begin
            logic [TW:0] sum;
            sum = {1'b0, pm_cross[ax]} + {1'b0, pm_delta[ax]};
            pm_cross[ax] = sum[TW] ? T_INF : sum[TW-1:0];
        end
        return ST_PROBE;
    endfunction

    // Work out the result of one accepted item and advance the prediction.
    function automatic t_out_item predict_voxel(input t_in_item it);
        t_out_item r;
        logic [31:0] starts [3];
        logic [15:0] dirs [3];
        logic [1:0] st;
        starts = '{it.start_x, it.start_y, it.start_z};
        dirs = '{it.dir_x, it.dir_y, it.dir_z};
        if (it.kind == 1'b0) begin
            for (int i = 0; i < 3; i++) begin
                logic [16:0] mag;
                logic [16:0] gap;
                logic [63:0] prod;
                pm_pos[i] = starts[i][31:16];
                pm_prev[i] = pm_pos[i];
                if (dirs[i] == 16'd0) begin
                    pm_sign[i] = SG_NONE;
                    pm_delta[i] = T_INF;
                    pm_cross[i] = T_INF;
                end else begin
                    if (dirs[i][15]) begin
                        pm_sign[i] = SG_NEG;
                        mag = 17'h10000 - {1'b0, dirs[i]};
                        gap = {1'b0, starts[i][15:0]};
                    end else begin
                        pm_sign[i] = SG_POS;
                        mag = {1'b0, dirs[i]};
                        gap = {1'b0, 16'(17'h10000 - {1'b0, starts[i][15:0]})};
                    end
                    pm_delta[i] = 32'(64'h8000_0000 / mag);
                    prod = 64'(gap) * 64'(pm_delta[i]);
                    pm_cross[i] = prod[47:16];
                end
            end
            pm_active = 1'b1;
            st = advance_voxel();
        end else if (!pm_active) begin
            st = ST_IDLE;
        end else if (it.solid) begin
            pm_active = 1'b0;
            st = ST_HIT;
        end else begin
            st = advance_voxel();
        end
        r.cell_x = pm_pos[0];
        r.cell_y = pm_pos[1];
        r.cell_z = pm_pos[2];
        r.prev_x = pm_prev[0];
        r.prev_y = pm_prev[1];
        r.prev_z = pm_prev[2];
        r.status = st;
        return r;
    endfunction

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input t_in_item it);
        repeat ($urandom_range(0, 3)) @(negedge i_clk);
        i_item = it;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_voxels.push_back(predict_voxel(it));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_ray(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz, input logic [15:0] dx,
                            input logic [15:0] dy, input logic [15:0] dz);
        t_in_item it;
        it = '{kind: 1'b0, start_x: sx, start_y: sy, start_z: sz,
               dir_x: dx, dir_y: dy, dir_z: dz, solid: 1'b0};
        send_item(it);
    endtask

    task automatic send_answer(input logic solid);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.kind = 1'b1;
        it.solid = solid;
        send_item(it);
    endtask

    task automatic wait_idle();
        while (expected_voxels.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_distance(input logic [31:0] value);
        wait_idle();
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        pm_max_dist = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] random_dir();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'(int'($urandom_range(1, 8)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_start();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return {16'($signed(int'($urandom_range(0, 20)) - 10)), 16'($urandom)};
    endfunction

    // Directed: answers with no ray, axis extremes, boundaries, ties, hits.
    task automatic test_directed();
        send_answer(1'b0);
        send_answer(1'b1);
        send_ray(32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 16'h4000, 16'h2000, 16'h1000);
        send_answer(1'b0);
        send_answer(1'b0);
        send_answer(1'b1);
        send_answer(1'b0);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h7FFF, 16'h0);
        send_answer(1'b0);
        send_ray(32'hFFFF_0000, 32'h0000_FFFF, 32'h0, 16'h4000, 16'h4000, 16'h4000);
        send_answer(1'b0);
        send_answer(1'b0);
        send_ray(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_answer(1'b0);
        send_ray(32'h0, 32'h0, 32'h0, 16'hFFFF, 16'h0, 16'h0001);
        send_answer(1'b0);
        send_ray(32'h0, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h4000);
        send_answer(1'b0);
    endtask

    task automatic test_range_settings();
        write_max_distance(32'h0);
        send_ray(32'h0000_8000, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0);
        send_answer(1'b0);
        write_max_distance(32'hFFFF_FFFF);
        send_ray(32'h0000_8000, 32'h0, 32'h0, 16'h0001, 16'h0, 16'h0);
        for (int i = 0; i < 3; i++) send_answer(1'b0);
        write_max_distance(32'h0002_0000);
    endtask

    // Mostly full rays with random answer runs, plus some stray answers.
    task automatic test_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_answer(1'($urandom_range(0, 1)));
                sent++;
            end else begin
                int run;
                send_ray(random_start(), random_start(), random_start(),
                         random_dir(), random_dir(), random_dir());
                run = $urandom_range(0, 12);
                sent += run + 1;
                for (int i = 0; i < run; i++) send_answer($urandom_range(0, 5) == 0);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_receiver = 1'b1;
        for (int i = 0; i < 5; i++) send_answer(1'b0);
        send_ray(32'h0, 32'h0, 32'h0, 16'h1000, 16'h0800, 16'h0400);
        for (int i = 0; i < 8; i++) send_answer(1'b0);
    endtask

    // Receiver: random stall per result, and one long hold on request.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_stall = 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
                hold_receiver = 1'b0;
            end
            i_stall = ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
            if (i_stall) repeat ($urandom_range(0, 3)) @(negedge i_clk);
            i_stall = 1'b0;
            if ($urandom_range(0, 7) == 0) repeat (10) @(negedge i_clk);
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_voxels.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_item), 32'h0);
            end else begin
                t_out_item w;
                w = expected_voxels.pop_front();
                if (o_item.cell_x !== w.cell_x)
                    report_mismatch("cell_x", 32'(o_item.cell_x), 32'(w.cell_x));
                if (o_item.cell_y !== w.cell_y)
                    report_mismatch("cell_y", 32'(o_item.cell_y), 32'(w.cell_y));
                if (o_item.cell_z !== w.cell_z)
                    report_mismatch("cell_z", 32'(o_item.cell_z), 32'(w.cell_z));
                if (o_item.prev_x !== w.prev_x)
                    report_mismatch("prev_x", 32'(o_item.prev_x), 32'(w.prev_x));
                if (o_item.prev_y !== w.prev_y)
                    report_mismatch("prev_y", 32'(o_item.prev_y), 32'(w.prev_y));
                if (o_item.prev_z !== w.prev_z)
                    report_mismatch("prev_z", 32'(o_item.prev_z), 32'(w.prev_z));
                if (o_item.status !== w.status)
                    report_mismatch("status", 32'(o_item.status), 32'(w.status));
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        error_count = 0;
        hold_receiver = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        pm_max_dist = MAXD_RESET;
        pm_active = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pm_pos[i] = '0;
            pm_prev[i] = '0;
            pm_sign[i] = SG_NONE;
            pm_delta[i] = T_INF;
            pm_cross[i] = T_INF;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_range_settings();
        test_random(500);
        test_backpressure();
        write_max_distance(MAXD_RESET);
        test_random(600);
        wait_idle();
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && expected_voxels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
